[rtl/core/assert_macros.svh]
// Assertion macros shared by the rate limit filter RTL.
// Depends on nothing; the user supplies a clock named aclk and a reset named aresetn.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define SRL_ASSERT_ALWAYS(lbl, expr) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (expr)) \
        else $error("assertion failed");
`define SRL_ASSERT_IMPLY(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("assertion failed");
`else
`define SRL_ASSERT_ALWAYS(lbl, expr)
`define SRL_ASSERT_IMPLY(lbl, ante, cons)
`endif
`endif

[rtl/core/srlf_pkg.sv]
// Package of the rate limit filter: word types, opcodes, cause and status codes.
// Depends on nothing.
package srlf_pkg;

    typedef struct packed {
        logic [2:0]  opcode;
        logic [31:0] source_key;
        logic [31:0] now;
    } in_word_t;

    typedef struct packed {
        logic        verdict;
        logic [2:0]  cause;
        logic [16:0] request_count;
        logic [1:0]  status;
        logic [31:0] total_checked;
        logic [31:0] total_blocked;
    } out_word_t;

    localparam logic [2:0] OP_CHECK  = 3'd0;
    localparam logic [2:0] OP_ALLOW  = 3'd1;
    localparam logic [2:0] OP_DENY   = 3'd2;
    localparam logic [2:0] OP_REMOVE = 3'd3;
    localparam logic [2:0] OP_CLEAR  = 3'd4;

    localparam logic [2:0] CAUSE_RULE_ALLOW = 3'd0;
    localparam logic [2:0] CAUSE_RULE_DENY  = 3'd1;
    localparam logic [2:0] CAUSE_WITHIN     = 3'd2;
    localparam logic [2:0] CAUSE_EXCEEDED   = 3'd3;
    localparam logic [2:0] CAUSE_TABLE_FULL = 3'd4;

    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_FULL      = 2'd1;
    localparam logic [1:0] STATUS_NOT_FOUND = 2'd2;

    localparam logic CFG_RATE_LIMIT  = 1'b0;
    localparam logic CFG_RATE_WINDOW = 1'b1;

    localparam logic [15:0] RATE_LIMIT_RESET  = 16'd100;
    localparam logic [15:0] RATE_WINDOW_RESET = 16'd60;
    localparam logic [16:0] COUNT_MAX         = 17'd65536;

endpackage

[rtl/core/srlf_ram.sv]
// Simple dual-port synchronous RAM with registered read data.
// Depends on srlf_pkg only by project convention.
module srlf_ram
    import srlf_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[rtl/core/source_rate_limit_filter.sv]
// Per-source rate limit filter with allow and deny rules, tables held in RAM.
// Each word scans the rules in use linearly, a read and a compare state per RAM entry; check
// words that hit no rule scan the trackers in use the same way; clear and unused go straight
// to the result. Words are taken only while idle, so a new word waits until the last result
// is loaded, and a result held by the sink stalls the input.
// Reset (aresetn low, synchronous) empties both tables and totals without a clearing pass.
module source_rate_limit_filter
    import srlf_pkg::*;
#(
    parameter int RULE_ENTRIES    = 256,
    parameter int TRACKER_ENTRIES = 1024,
    parameter int KEY_BITS        = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wen,
    input  logic        cfg_index,
    input  logic [15:0] cfg_wdata,
    input  logic        s_valid,
    output logic        s_ready,
    input  in_word_t    s_data,
    output logic        m_valid,
    input  logic        m_ready,
    output out_word_t   m_data
);

    `include "assert_macros.svh"

    // Index and counter widths. Counters hold the table depth itself.
    localparam int RAW  = (RULE_ENTRIES > 1) ? $clog2(RULE_ENTRIES) : 1;
    localparam int TAW  = (TRACKER_ENTRIES > 1) ? $clog2(TRACKER_ENTRIES) : 1;
    localparam int RUW  = $clog2(RULE_ENTRIES + 1);
    localparam int TUW  = $clog2(TRACKER_ENTRIES + 1);
    localparam int SW   = (RUW > TUW) ? RUW : TUW;
    localparam int RW   = KEY_BITS + 1;
    localparam int TW   = KEY_BITS + 17 + 32;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_R_RD   = 3'd1;
    localparam logic [2:0] ST_R_CMP  = 3'd2;
    localparam logic [2:0] ST_T_RD   = 3'd3;
    localparam logic [2:0] ST_T_CMP  = 3'd4;
    localparam logic [2:0] ST_T_UPD  = 3'd5;
    localparam logic [2:0] ST_RESULT = 3'd6;

    logic [2:0]          state_reg, state_next;
    logic [2:0]          op_reg, op_next;
    logic [KEY_BITS-1:0] key_reg, key_next;
    logic [31:0]         now_reg, now_next;
    logic [SW-1:0]       idx_reg, idx_next;
    logic [RUW-1:0]      rules_used_reg, rules_used_next;
    logic [TUW-1:0]      trackers_used_reg, trackers_used_next;
    logic [RULE_ENTRIES-1:0] active_reg, active_next;
    logic [15:0]         limit_reg, limit_next;
    logic [15:0]         window_reg, window_next;
    logic [31:0]         checked_reg, checked_next;
    logic [31:0]         blocked_reg, blocked_next;
    logic [16:0]         cnt_reg, cnt_next;
    logic [31:0]         ws_reg, ws_next;
    logic                append_reg, append_next;
    logic                verdict_reg, verdict_next;
    logic [2:0]          cause_reg, cause_next;
    logic [16:0]         count_reg, count_next;
    logic [1:0]          status_reg, status_next;
    logic                m_valid_reg, m_valid_next;
    out_word_t           m_data_reg, m_data_next;

    // RAM ports.
    logic          rule_we;
    logic [RW-1:0] rule_wdata, rule_rdata;
    logic          trk_we;
    logic [TW-1:0] trk_wdata, trk_rdata;

    logic                rule_hit;
    logic                rules_full;
    logic [KEY_BITS-1:0] rd_rule_key;
    logic                rd_rule_deny;
    logic [KEY_BITS-1:0] rd_trk_key;
    logic [31:0]         elapsed;
    logic                restart;
    logic [16:0]         cnt_base, cnt_new;
    logic [31:0]         ws_new;
    logic                over;

    srlf_ram #(.WIDTH(RW), .DEPTH(RULE_ENTRIES), .AW(RAW)) u_rule_ram (
        .aclk  (aclk),
        .we    (rule_we),
        .waddr (idx_reg[RAW-1:0]),
        .wdata (rule_wdata),
        .raddr (idx_reg[RAW-1:0]),
        .rdata (rule_rdata)
    );

    srlf_ram #(.WIDTH(TW), .DEPTH(TRACKER_ENTRIES), .AW(TAW)) u_trk_ram (
        .aclk  (aclk),
        .we    (trk_we),
        .waddr (idx_reg[TAW-1:0]),
        .wdata (trk_wdata),
        .raddr (idx_reg[TAW-1:0]),
        .rdata (trk_rdata)
    );

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // Rule entry: key above the deny flag. Tracker entry: key, count, window start.
    assign rd_rule_key  = rule_rdata[RW-1:1];
    assign rd_rule_deny = rule_rdata[0];
    assign rd_trk_key   = trk_rdata[TW-1:49];
    assign rule_hit     = active_reg[idx_reg[RAW-1:0]] && (rd_rule_key == key_reg);
    assign rules_full   = (idx_reg >= SW'(RULE_ENTRIES));

    // Window arithmetic wraps modulo 2^32; the count saturates at its ceiling.
    assign elapsed  = now_reg - ws_reg;
    assign restart  = (elapsed >= {16'd0, window_reg});
    assign cnt_base = restart ? 17'd0 : cnt_reg;
    assign cnt_new  = (cnt_base == COUNT_MAX) ? cnt_base : cnt_base + 17'd1;
    assign ws_new   = restart ? now_reg : ws_reg;
    assign over     = (cnt_new > {1'b0, limit_reg});

    always_comb begin
        state_next         = state_reg;
        op_next            = op_reg;
        key_next           = key_reg;
        now_next           = now_reg;
        idx_next           = idx_reg;
        rules_used_next    = rules_used_reg;
        trackers_used_next = trackers_used_reg;
        active_next        = active_reg;
        limit_next         = limit_reg;
        window_next        = window_reg;
        checked_next       = checked_reg;
        blocked_next       = blocked_reg;
        cnt_next           = cnt_reg;
        ws_next            = ws_reg;
        append_next        = append_reg;
        verdict_next       = verdict_reg;
        cause_next         = cause_reg;
        count_next         = count_reg;
        status_next        = status_reg;
        m_valid_next       = m_valid_reg;
        m_data_next        = m_data_reg;
        rule_we            = 1'b0;
        rule_wdata         = {key_reg, (op_reg == OP_DENY)};
        trk_we             = 1'b0;
        trk_wdata          = {key_reg, cnt_new, ws_new};

        // Configuration is only to be written while idle; the block itself does not enforce it.
        if (cfg_wen) begin
            if (cfg_index == CFG_RATE_LIMIT) begin
                limit_next = cfg_wdata;
            end else begin
                window_next = cfg_wdata;
            end
        end

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    op_next      = s_data.opcode;
                    key_next     = KEY_BITS'(s_data.source_key);
                    now_next     = s_data.now;
                    idx_next     = '0;
                    verdict_next = 1'b0;
                    cause_next   = CAUSE_RULE_ALLOW;
                    count_next   = '0;
                    status_next  = STATUS_OK;
                    append_next  = 1'b0;
                    if (s_data.opcode == OP_CHECK) begin
                        if (checked_reg != '1) begin
                            checked_next = checked_reg + 32'd1;
                        end
                        state_next = ST_R_RD;
                    end else if (s_data.opcode == OP_ALLOW || s_data.opcode == OP_DENY ||
                                 s_data.opcode == OP_REMOVE) begin
                        state_next = ST_R_RD;
                    end else if (s_data.opcode == OP_CLEAR) begin
                        rules_used_next    = '0;
                        trackers_used_next = '0;
                        active_next        = '0;
                        state_next         = ST_RESULT;
                    end else begin
                        state_next = ST_RESULT;
                    end
                end
            end
            ST_R_RD: begin
                if (idx_reg == SW'(rules_used_reg)) begin
                    // No active rule on this key; idx now points at the next free slot.
                    state_next = ST_RESULT;
                    if (op_reg == OP_CHECK) begin
                        idx_next   = '0;
                        state_next = ST_T_RD;
                    end else if (op_reg == OP_REMOVE) begin
                        status_next = STATUS_NOT_FOUND;
                    end else if (rules_full) begin
                        status_next = STATUS_FULL;
                    end else begin
                        rule_we                        = 1'b1;
                        active_next[idx_reg[RAW-1:0]]  = 1'b1;
                        rules_used_next                = rules_used_reg + RUW'(1);
                    end
                end else begin
                    state_next = ST_R_CMP;
                end
            end
            ST_R_CMP: begin
                if (rule_hit) begin
                    state_next = ST_RESULT;
                    if (op_reg == OP_CHECK) begin
                        if (rd_rule_deny) begin
                            verdict_next = 1'b1;
                            cause_next   = CAUSE_RULE_DENY;
                            if (blocked_reg != '1) begin
                                blocked_next = blocked_reg + 32'd1;
                            end
                        end
                    end else if (op_reg == OP_REMOVE) begin
                        active_next[idx_reg[RAW-1:0]] = 1'b0;
                    end else begin
                        rule_we = 1'b1;
                    end
                end else begin
                    idx_next   = idx_reg + SW'(1);
                    state_next = ST_R_RD;
                end
            end
            ST_T_RD: begin
                if (idx_reg == SW'(trackers_used_reg)) begin
                    if (idx_reg >= SW'(TRACKER_ENTRIES)) begin
                        cause_next = CAUSE_TABLE_FULL;
                        state_next = ST_RESULT;
                    end else begin
                        cnt_next    = '0;
                        ws_next     = now_reg;
                        append_next = 1'b1;
                        state_next  = ST_T_UPD;
                    end
                end else begin
                    state_next = ST_T_CMP;
                end
            end
            ST_T_CMP: begin
                if (rd_trk_key == key_reg) begin
                    cnt_next   = trk_rdata[48:32];
                    ws_next    = trk_rdata[31:0];
                    state_next = ST_T_UPD;
                end else begin
                    idx_next   = idx_reg + SW'(1);
                    state_next = ST_T_RD;
                end
            end
            ST_T_UPD: begin
                trk_we     = 1'b1;
                count_next = cnt_new;
                if (append_reg) begin
                    trackers_used_next = trackers_used_reg + TUW'(1);
                end
                if (over) begin
                    verdict_next = 1'b1;
                    cause_next   = CAUSE_EXCEEDED;
                    if (blocked_reg != '1) begin
                        blocked_next = blocked_reg + 32'd1;
                    end
                end else begin
                    cause_next = CAUSE_WITHIN;
                end
                state_next = ST_RESULT;
            end
            ST_RESULT: begin
                // The output register frees as soon as the previous word is taken.
                if (!m_valid_reg || m_ready) begin
                    m_valid_next              = 1'b1;
                    m_data_next.verdict       = verdict_reg;
                    m_data_next.cause         = cause_reg;
                    m_data_next.request_count = count_reg;
                    m_data_next.status        = status_reg;
                    m_data_next.total_checked = checked_reg;
                    m_data_next.total_blocked = blocked_reg;
                    state_next                = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= ST_IDLE;
            rules_used_reg    <= '0;
            trackers_used_reg <= '0;
            active_reg        <= '0;
            limit_reg         <= RATE_LIMIT_RESET;
            window_reg        <= RATE_WINDOW_RESET;
            checked_reg       <= '0;
            blocked_reg       <= '0;
            m_valid_reg       <= 1'b0;
        end else begin
            state_reg         <= state_next;
            rules_used_reg    <= rules_used_next;
            trackers_used_reg <= trackers_used_next;
            active_reg        <= active_next;
            limit_reg         <= limit_next;
            window_reg        <= window_next;
            checked_reg       <= checked_next;
            blocked_reg       <= blocked_next;
            m_valid_reg       <= m_valid_next;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge aclk) begin
        op_reg      <= op_next;
        key_reg     <= key_next;
        now_reg     <= now_next;
        idx_reg     <= idx_next;
        cnt_reg     <= cnt_next;
        ws_reg      <= ws_next;
        append_reg  <= append_next;
        verdict_reg <= verdict_next;
        cause_reg   <= cause_next;
        count_reg   <= count_next;
        status_reg  <= status_next;
        m_data_reg  <= m_data_next;
    end

    // The fill counters never pass the table depths.
    `SRL_ASSERT_ALWAYS(a_rules_bound, rules_used_reg <= RUW'(RULE_ENTRIES))
    `SRL_ASSERT_ALWAYS(a_trk_bound, trackers_used_reg <= TUW'(TRACKER_ENTRIES))
    // A blocked word always names a deny rule or an exceeded rate.
    `SRL_ASSERT_IMPLY(a_block_cause, m_valid_reg && m_data_reg.verdict,
        (m_data_reg.cause == CAUSE_RULE_DENY) || (m_data_reg.cause == CAUSE_EXCEEDED))

endmodule
